// ===== design/grid_path_reachability_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the grid path reachability block.
// ---------------------------------------------------------------------------
`ifndef GRID_PATH_REACHABILITY_ASSERT_SVH
`define GRID_PATH_REACHABILITY_ASSERT_SVH
`ifndef ASSERT_OFF
`define GPR_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GPR_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPR_ASSERT_IMPL(label, clk, rst, prop, msg)
`define GPR_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`endif
`endif

// ===== design/gpr_pkg.sv =====
// ---------------------------------------------------------------------------
// gpr_pkg
// Shared types and codes for the grid path reachability block.
// ---------------------------------------------------------------------------
`default_nettype none
package gpr_pkg;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SWEEP,
      ST_CHECK,
      ST_FINISH,
      ST_RESULT
   } state_type;
endpackage
`default_nettype wire

// ===== design/grid_path_reachability.sv =====
// The block holds a GRID_SIZE square occupancy grid in a RAM of one row per
// word and answers 4-connected path queries by flood fill. A write beat is
// accepted, then its row is read and written back with the new cell; a write
// outside the grid changes nothing. No new beat is taken before a beat is
// done. A query beat first clears the reached-row RAM. It then sweeps the
// rows top to bottom and back again; each row is read, then grown and written
// back. Each row is grown horizontally until it is stable within the row.
// Passes repeat until one pass changes nothing, so at least two passes run,
// and their number grows with the number of times a path has to turn back
// vertically. A query whose source lies outside the grid skips the sweeps
// and is answered as unreachable. The answer goes to an output register, and
// the next beat may be accepted while it waits. A later answer waits in its
// last state until that register is free. After reset the occupancy RAM is
// cleared before the first beat is taken.
// ---------------------------------------------------------------------------
// grid_path_reachability
// Occupancy grid with flood-fill path queries.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_path_reachability_assert.svh"
module grid_path_reachability #(
   parameter int GRID_SIZE = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_op,
   input  wire logic [3:0] req_src_x,
   input  wire logic [3:0] req_src_y,
   input  wire logic [3:0] req_dst_x,
   input  wire logic [3:0] req_dst_y,
   input  wire logic       req_occupied,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_reachable
);
   localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
   localparam int CW = $clog2(GRID_SIZE + 1);

   gpr_pkg::state_type state_ff, state_in;
   logic [CW-1:0] row_ff, row_in;       // current row of a pass
   logic          dir_ff, dir_in;       // 0 downward, 1 upward
   logic          phase_ff, phase_in;   // 0 issue read, 1 data back
   logic          changed_ff, changed_in;
   logic          op_ff, occ_ff, src_ok_ff, dst_ok_ff;
   logic [AW-1:0] sx_ff, sy_ff, dx_ff, dy_ff;
   logic          wr_pend_ff, wr_pend_in;
   logic          rsp_valid_ff, rsp_valid_in, reach_ff, reach_in;
   logic          ans_ff, ans_in;           // answer waiting for the output register
   logic [GRID_SIZE-1:0] prev_ff, prev_in;  // reached row just processed

   logic              occ_we, rch_we;
   logic [AW-1:0]     occ_wa, rch_wa, occ_ra, rch_ra;
   logic [GRID_SIZE-1:0] occ_wd, rch_wd, occ_rd, rch_rd, nb_rd;
   logic [AW-1:0]     nb_ra;

   gpr_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_occ (
      .clock(clock), .wr_en(occ_we), .wr_addr(occ_wa), .wr_data(occ_wd),
      .rd_addr(occ_ra), .rd_data(occ_rd));
   gpr_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_rch (
      .clock(clock), .wr_en(rch_we), .wr_addr(rch_wa), .wr_data(rch_wd),
      .rd_addr(rch_ra), .rd_data(rch_rd));
   // The neighbor on the far side of the pass direction is read from a copy.
   gpr_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_nb (
      .clock(clock), .wr_en(rch_we), .wr_addr(rch_wa), .wr_data(rch_wd),
      .rd_addr(nb_ra), .rd_data(nb_rd));

   logic [AW-1:0] row_a;
   logic          has_next;
   logic [GRID_SIZE-1:0] pass_row, grow, seed, src_bit;

   assign row_a = row_ff[AW-1:0];

   // Horizontal spread within one row: doubling steps reach any run length.
   function automatic logic [GRID_SIZE-1:0] spread(input logic [GRID_SIZE-1:0] s,
                                                  input logic [GRID_SIZE-1:0] p);
      logic [GRID_SIZE-1:0] gl, gr, al, ar;
      gl = s & p;
      gr = gl;
      al = p;
      ar = p;
      for (int k = 1; k < GRID_SIZE; k = k * 2) begin
         gl = gl | (al & (gl << k));
         al = al & (al << k);
         gr = gr | (ar & (gr >> k));
         ar = ar & (ar >> k);
      end
      return gl | gr;
   endfunction

   always_comb begin
      src_bit = '0;
      src_bit[sx_ff] = 1'b1;
      pass_row = ~occ_rd;
      seed = rch_rd | prev_ff;
      if (row_a == sy_ff) begin
         // The source counts as free and seeds its own row.
         pass_row = pass_row | src_bit;
         seed = seed | src_bit;
      end
      if (dir_ff ? (row_ff != '0) : (row_ff != CW'(GRID_SIZE - 1))) begin
         seed = seed | nb_rd;
      end
      grow = spread(seed, pass_row);
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      dir_in = dir_ff;
      phase_in = phase_ff;
      changed_in = changed_ff;
      wr_pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      reach_in = reach_ff;
      ans_in = ans_ff;
      prev_in = prev_ff;
      req_ready = 1'b0;
      occ_we = 1'b0; occ_wa = row_a; occ_wd = '0; occ_ra = row_a;
      rch_we = 1'b0; rch_wa = row_a; rch_wd = '0; rch_ra = row_a;
      nb_ra = dir_ff ? AW'(row_ff - 1'b1) : AW'(row_ff + 1'b1);
      has_next = dir_ff ? (row_ff != '0) : (row_ff != CW'(GRID_SIZE - 1));
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         gpr_pkg::ST_INIT: begin
            occ_we = 1'b1;
            rch_we = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_ff == CW'(GRID_SIZE - 1)) begin
               state_in = gpr_pkg::ST_IDLE;
            end
         end
         gpr_pkg::ST_IDLE: begin
            occ_ra = sy_ff;
            if (wr_pend_ff) begin
               // Row read issued last cycle is back; modify and write.
               occ_we = 1'b1;
               occ_wa = sy_ff;
               occ_wd = occ_rd;
               occ_wd[sx_ff] = occ_ff;
            end else if (op_ff == gpr_pkg::OP_WRITE && phase_ff) begin
               phase_in = 1'b0;
               wr_pend_in = 1'b1;
            end else begin
               req_ready = 1'b1;
               if (req_valid && req_ready) begin
                  if (req_op == gpr_pkg::OP_QUERY) begin
                     state_in = gpr_pkg::ST_CLEAR;
                     row_in = '0;
                  end else begin
                     phase_in = (req_src_x < GRID_SIZE) && (req_src_y < GRID_SIZE);
                  end
               end
            end
         end
         gpr_pkg::ST_CLEAR: begin
            rch_we = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_ff == CW'(GRID_SIZE - 1)) begin
               if (!src_ok_ff) begin
                  ans_in = 1'b0;
                  state_in = gpr_pkg::ST_RESULT;
               end else begin
                  state_in = gpr_pkg::ST_SWEEP;
                  row_in = '0;
                  dir_in = 1'b0;
                  phase_in = 1'b0;
                  changed_in = 1'b0;
                  prev_in = '0;
               end
            end
         end
         gpr_pkg::ST_SWEEP: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               rch_we = 1'b1;
               rch_wd = grow;
               if (rch_wd != rch_rd) begin
                  changed_in = 1'b1;
               end
               prev_in = rch_wd;
               phase_in = 1'b0;
               if (has_next) begin
                  row_in = dir_ff ? row_ff - 1'b1 : row_ff + 1'b1;
               end else begin
                  prev_in = '0;
                  if (!changed_in) begin
                     state_in = gpr_pkg::ST_CHECK;
                     row_in = CW'(dy_ff);
                  end else begin
                     dir_in = !dir_ff;
                     changed_in = 1'b0;
                  end
               end
            end
         end
         gpr_pkg::ST_CHECK: begin
            rch_ra = dy_ff;
            state_in = gpr_pkg::ST_FINISH;
         end
         gpr_pkg::ST_FINISH: begin
            ans_in = dst_ok_ff && rch_rd[dx_ff];
            state_in = gpr_pkg::ST_RESULT;
         end
         gpr_pkg::ST_RESULT: begin
            // Wait here until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               reach_in = ans_ff;
               state_in = gpr_pkg::ST_IDLE;
               phase_in = 1'b0;
            end
         end
         default: state_in = gpr_pkg::ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpr_pkg::ST_INIT;
         row_ff <= '0;
         dir_ff <= 1'b0;
         phase_ff <= 1'b0;
         changed_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff <= gpr_pkg::OP_QUERY;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         dir_ff <= dir_in;
         phase_ff <= phase_in;
         changed_ff <= changed_in;
         wr_pend_ff <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_valid && req_ready) begin
            op_ff <= req_op;
         end
      end
   end

   always_ff @(posedge clock) begin
      reach_ff <= reach_in;
      ans_ff <= ans_in;
      prev_ff <= prev_in;
      if (req_valid && req_ready) begin
         occ_ff <= req_occupied;
         sx_ff <= AW'(req_src_x);
         sy_ff <= AW'(req_src_y);
         dx_ff <= AW'(req_dst_x);
         dy_ff <= AW'(req_dst_y);
         src_ok_ff <= (req_src_x < GRID_SIZE) && (req_src_y < GRID_SIZE);
         dst_ok_ff <= (req_dst_x < GRID_SIZE) && (req_dst_y < GRID_SIZE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_reachable = reach_ff;

   `GPR_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready |-> state_ff == gpr_pkg::ST_IDLE, "ready outside idle")
   `GPR_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(reach_ff), "result changed while waiting")
   `GPR_ASSERT_IMPL(a_result_after, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == gpr_pkg::ST_RESULT, "result without query end")
   `GPR_ASSERT_ALWAYS(a_reset_quiet, clock, 1'b0, reset |=> !rsp_valid_ff && !req_ready, "activity after reset")
endmodule
`default_nettype wire

// ===== design/gpr_ram.sv =====
// ---------------------------------------------------------------------------
// gpr_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module gpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
